FILE: src/tcpwm_pkg.sv
package tcpwm_pkg;

    localparam int COUNT_W    = 8;
    localparam int PRESCALE_W = 10;
    localparam int DIVISOR_W  = PRESCALE_W + 1;

    localparam logic [1:0] MODE_NORMAL   = 2'd0;
    localparam logic [1:0] MODE_CTC      = 2'd1;
    localparam logic [1:0] MODE_PWM      = 2'd2;
    localparam logic [1:0] MODE_PWM_ALT  = 2'd3;

    localparam logic [1:0] ACT_OFF       = 2'd0;
    localparam logic [1:0] ACT_TOGGLE    = 2'd1;
    localparam logic [1:0] ACT_CLEAR     = 2'd2;
    localparam logic [1:0] ACT_SET       = 2'd3;

    localparam logic       CMD_TICK      = 1'b0;
    localparam logic       CMD_LOAD      = 1'b1;

    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_PRESCALE  = 2'd1;
    localparam logic [1:0] REG_COMPARE   = 2'd2;
    localparam logic [1:0] REG_ACTION    = 2'd3;

    localparam logic [2:0] PRE_STOP      = 3'd0;
    localparam logic [2:0] PRE_DIV1      = 3'd1;
    localparam logic [2:0] PRE_DIV8      = 3'd2;
    localparam logic [2:0] PRE_DIV64     = 3'd3;
    localparam logic [2:0] PRE_DIV256    = 3'd4;
    localparam logic [2:0] PRE_DIV1024   = 3'd5;

    localparam logic [COUNT_W-1:0] COUNT_TOP = 8'hFF;

    typedef struct packed {
        logic [1:0]         timer_mode;
        logic [2:0]         prescale_select;
        logic [COUNT_W-1:0] compare_value;
        logic [1:0]         output_action;
    } cfg_t;

    typedef struct packed {
        logic               pin_level;
        logic               compare_event;
        logic               overflow_event;
        logic [COUNT_W-1:0] count_now;
    } result_t;

    function automatic logic [DIVISOR_W-1:0] prescale_divisor(input logic [2:0] sel);
        logic [DIVISOR_W-1:0] d;
        d = '0;
        unique case (sel)
            PRE_DIV1:    d = 11'd1;
            PRE_DIV8:    d = 11'd8;
            PRE_DIV64:   d = 11'd64;
            PRE_DIV256:  d = 11'd256;
            PRE_DIV1024: d = 11'd1024;
            default:     d = '0;
        endcase
        return d;
    endfunction

    function automatic logic match_pin(input logic pin, input logic [1:0] action);
        logic p;
        p = pin;
        unique case (action)
            ACT_TOGGLE: p = ~pin;
            ACT_CLEAR:  p = 1'b0;
            ACT_SET:    p = 1'b1;
            default:    p = pin;
        endcase
        return p;
    endfunction

endpackage

FILE: src/tcpwm_cfg.sv
module tcpwm_cfg
    import tcpwm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [COUNT_W-1:0]  cfg_data,
    output cfg_t                cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:     cfg_reg.timer_mode      <= cfg_data[1:0];
                REG_PRESCALE: cfg_reg.prescale_select <= cfg_data[2:0];
                REG_COMPARE:  cfg_reg.compare_value   <= cfg_data;
                REG_ACTION:   cfg_reg.output_action   <= cfg_data[1:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/tcpwm_core.sv
module tcpwm_core
    import tcpwm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  logic                cmd,
    input  logic [COUNT_W-1:0]  load_value,
    input  cfg_t                cfg,
    output result_t             res
);

    logic [PRESCALE_W-1:0] prescale_count_reg, prescale_count_next;
    logic [COUNT_W-1:0]    timer_count_reg, timer_count_next;
    logic                  pin_reg, pin_next;

    logic [DIVISOR_W-1:0]  divisor;
    logic [DIVISOR_W-1:0]  prescale_inc;
    logic                  match;
    logic                  pwm_active;
    logic                  ovf;
    logic                  cmp;
    logic                  pwm_pin;

    assign divisor      = prescale_divisor(cfg.prescale_select);
    assign prescale_inc = {1'b0, prescale_count_reg} + 11'd1;
    assign match        = (timer_count_reg == cfg.compare_value);
    assign pwm_active   = (cfg.timer_mode == MODE_PWM) || (cfg.timer_mode == MODE_PWM_ALT);

    // In fast PWM the wrap action is applied after the match action, so it wins.
    always_comb
    begin
        pwm_pin = pin_reg;
        if (match)
        begin
            if (cfg.output_action == ACT_CLEAR)
                pwm_pin = 1'b0;
            else if (cfg.output_action == ACT_SET)
                pwm_pin = 1'b1;
        end
        if (timer_count_reg == COUNT_TOP)
        begin
            if (cfg.output_action == ACT_CLEAR)
                pwm_pin = 1'b1;
            else if (cfg.output_action == ACT_SET)
                pwm_pin = 1'b0;
        end
    end

    always_comb
    begin
        prescale_count_next = prescale_count_reg;
        timer_count_next    = timer_count_reg;
        pin_next            = pin_reg;
        ovf                 = 1'b0;
        cmp                 = 1'b0;
        if (cmd == CMD_LOAD)
        begin
            timer_count_next = load_value;
        end
        else if (divisor != '0)
        begin
            if (prescale_inc >= divisor)
            begin
                prescale_count_next = '0;
                cmp = match;
                if ((cfg.timer_mode == MODE_CTC) && match)
                begin
                    timer_count_next = '0;
                    pin_next = match_pin(pin_reg, cfg.output_action);
                end
                else
                begin
                    ovf = (timer_count_reg == COUNT_TOP);
                    timer_count_next = timer_count_reg + 8'd1;
                    if (pwm_active)
                        pin_next = pwm_pin;
                    else if (match)
                        pin_next = match_pin(pin_reg, cfg.output_action);
                end
            end
            else
            begin
                prescale_count_next = prescale_inc[PRESCALE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            timer_count_reg    <= '0;
            pin_reg            <= 1'b0;
        end
        else if (step_en)
        begin
            prescale_count_reg <= prescale_count_next;
            timer_count_reg    <= timer_count_next;
            pin_reg            <= pin_next;
        end
    end

    assign res.count_now      = timer_count_next;
    assign res.overflow_event = ovf;
    assign res.compare_event  = cmp;
    assign res.pin_level      = pin_next;

endmodule

FILE: src/timer_counter_normal_ctc_pwm.sv
// Eight-bit timer/counter with prescaler, clear-on-compare and fast PWM.
// Each request on the slave stream is either one clock tick (s_tuser low)
// or a counter load (s_tuser high, value in s_tdata).  Every request makes
// exactly one result request on the master stream, carrying the counter
// value after the request, the overflow and compare flags and the level of
// the compare output pin.
// A request is held in an input register, the timer step is computed
// combinationally from it, and the result lands in an output register
// that drives m_tvalid.  The timer state is updated in the same cycle,
// so one request per cycle is sustained while m_tready is high.
// When the receiver stalls, the result waits in the output register and
// one more request is still taken into the input register; after that
// s_tready drops until m_tready returns.
// The user must write the configuration through cfg_we, cfg_index and
// cfg_data only while the block is idle, which it does not enforce.
// Reset clears the configuration, the prescaler, the counter, the pin and both stream stages.
module timer_counter_normal_ctc_pwm
    import tcpwm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] load_value
    input  logic                s_tuser,   // [0] cmd
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // [7:0] count_now, [8] overflow_event,
                                           // [9] compare_event, [10] pin_level, rest zero
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    cfg_t                cfg;
    result_t             res;

    logic                in_valid_reg;
    logic                in_cmd_reg;
    logic [COUNT_W-1:0]  in_load_reg;
    logic                out_valid_reg;
    result_t             out_res_reg;
    logic                advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    tcpwm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tcpwm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .cmd        (in_cmd_reg),
        .load_value (in_load_reg),
        .cfg        (cfg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg  <= s_tuser;
            in_load_reg <= s_tdata;
        end
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_res_reg.pin_level, out_res_reg.compare_event,
                       out_res_reg.overflow_event, out_res_reg.count_now};

    a_ovf_wraps_to_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.overflow_event |-> out_res_reg.count_now == '0)
        else $error("overflow reported with nonzero count");

    a_ctc_clears : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.compare_event && cfg.timer_mode == MODE_CTC
        |-> out_res_reg.count_now == '0)
        else $error("CTC compare did not clear the counter");

    a_load_quiet : assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_cmd_reg == CMD_LOAD
        |=> !out_res_reg.overflow_event && !out_res_reg.compare_event
            && out_res_reg.count_now == $past(in_load_reg))
        else $error("load request produced events or wrong count");

endmodule
